// File: rtl/jet_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jet_pkg
// Shared types, constants and fixed-point helpers of the Julia escape-time core.
// ----------------------------------------------------------------------------
package jet_pkg;

	// fixed-point format: sign, three integer bits, FRAC_BITS fraction bits
	localparam int FRAC_BITS = 28;
	localparam int Q_W       = FRAC_BITS + 4;
	localparam int QX_W      = Q_W + 2;
	localparam int PROD_W    = 2 * Q_W;
	localparam int MAG_W     = PROD_W - FRAC_BITS + 1;

	// field and register widths
	localparam int PIX_W = 12;
	localparam int CNT_W = 16;
	localparam int CFG_W = 32;
	localparam int IDX_W = 2;

	typedef logic signed [Q_W-1:0]  q_t;
	typedef logic signed [QX_W-1:0] qx_t;
	typedef logic [PROD_W-1:0]      prod_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	localparam q_t QMAX  = {1'b0, {(Q_W-1){1'b1}}};
	localparam q_t QMIN  = {1'b1, {(Q_W-1){1'b0}}};
	localparam q_t TWO_Q = q_t'(2) <<< FRAC_BITS;

	// escape radius squared (4.0) at the scale of a full product
	localparam logic [PROD_W:0] RADIUS_SQ = (PROD_W+1)'(1) << (2 * FRAC_BITS + 2);

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_C_REAL   = 2'd0;
	localparam logic [IDX_W-1:0] REG_C_IMAG   = 2'd1;
	localparam logic [IDX_W-1:0] REG_MAX_ITER = 2'd2;

	localparam cnt_t MAX_ITER_RESET = cnt_t'(10000);

	// register values as seen by the iteration engine
	typedef struct packed {
		q_t   c_real;
		q_t   c_imag;
		cnt_t iter_limit;
	} cfg_t;

	// start point handed from the mapper to the iteration engine
	typedef struct packed {
		q_t x;
		q_t y;
	} point_t;

	// clamp a widened value into the Q4 range
	function automatic q_t sat_q(qx_t v);
		if (v > qx_t'(QMAX)) begin
			return QMAX;
		end else if (v < qx_t'(QMIN)) begin
			return QMIN;
		end
		return v[Q_W-1:0];
	endfunction

	// magnitude of a Q4 value, unsigned
	function automatic logic [Q_W-1:0] mag_q(q_t v);
		return v[Q_W-1] ? (~v + Q_W'(1)) : v;
	endfunction

	// product of magnitudes back to Q4: floor toward minus infinity, then saturate
	function automatic q_t prod_to_q(prod_t p, logic neg);
		logic [MAG_W-1:0] m;
		logic             rnd;
		rnd = neg & (|p[FRAC_BITS-1:0]);
		m   = {1'b0, p[PROD_W-1:FRAC_BITS]} + MAG_W'(rnd);
		if (!neg) begin
			if (m > MAG_W'(QMAX)) begin
				return QMAX;
			end
			return m[Q_W-1:0];
		end
		if (m > (MAG_W'(1) << (Q_W - 1))) begin
			return QMIN;
		end
		return ~m[Q_W-1:0] + Q_W'(1);
	endfunction

endpackage
`default_nettype wire

// File: rtl/jet_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jet channel interfaces
// Valid/ready channels for pixels, start points and results.
// ----------------------------------------------------------------------------

// pixel word
interface jet_pix_if;
	import jet_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;
	modport source (output valid, pixel_x, pixel_y, input ready);
	modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

// start point word
interface jet_pt_if;
	import jet_pkg::*;
	logic   valid;
	logic   ready;
	point_t point;
	modport source (output valid, point, input ready);
	modport sink   (input valid, point, output ready);
endinterface

// result word
interface jet_res_if;
	import jet_pkg::*;
	logic valid;
	logic ready;
	cnt_t iteration_count;
	logic in_set;
	modport source (output valid, iteration_count, in_set, input ready);
	modport sink   (input valid, iteration_count, in_set, output ready);
endinterface
`default_nettype wire

// File: rtl/jet_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jet_front
// Maps a pixel pair to a Q4 start point by constant reciprocal multiplication.
// ----------------------------------------------------------------------------
module jet_front #(
	parameter int IMAGE_SIZE = 4096
) (
	input  logic   clk,
	input  logic   arst_n,
	jet_pix_if.sink pix,
	jet_pt_if.source pt
);
	import jet_pkg::*;

	// 4*p*2^F / IMAGE_SIZE = p*WHOLE + floor(p*PART / IMAGE_SIZE), with WHOLE and
	// PART the quotient and remainder of 2^(F+2) by the image size; the second
	// term is an exact multiply by a rounded-up reciprocal
	localparam int     NUM_W  = PIX_W + 2 + FRAC_BITS;
	localparam int     DIV_W  = $clog2(IMAGE_SIZE);
	localparam int     PART_W = PIX_W + DIV_W;
	localparam int     RCP_SH = PART_W + DIV_W;
	localparam int     RCP_W  = PART_W + 2;
	localparam int     FPR_W  = PART_W + RCP_W;
	localparam longint SCALE  = longint'(1) << (FRAC_BITS + 2);
	localparam logic [NUM_W-1:0]  WHOLE = NUM_W'(SCALE / IMAGE_SIZE);
	localparam logic [PART_W-1:0] PART  = PART_W'(SCALE % IMAGE_SIZE);
	localparam logic [RCP_W-1:0]  RECIP =
		RCP_W'(((longint'(1) << RCP_SH) + longint'(IMAGE_SIZE) - 1) / IMAGE_SIZE);
	localparam logic [NUM_W-1:0]  TEN_Q = NUM_W'(10) << FRAC_BITS;

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_SUM  = 4'b0100,
		F_PUSH = 4'b1000
	} front_state_t;

	front_state_t      state_q;
	logic [PIX_W-1:0]  px_q, py_q;
	logic [NUM_W-1:0]  wholex_q, wholey_q;
	logic [PART_W-1:0] partx_q, party_q;
	logic [NUM_W-1:0]  quox_q, quoy_q;

	logic [FPR_W-1:0]  fracx, fracy;
	logic [Q_W-1:0]    qcx, qcy;
	logic signed [Q_W:0] dx, dy;
	point_t            start;

	// reciprocal multiply, the quotient starts at bit RCP_SH
	assign fracx = FPR_W'(partx_q) * FPR_W'(RECIP);
	assign fracy = FPR_W'(party_q) * FPR_W'(RECIP);

	// saturate the scaled pixel at 10.0, then x = value - 2.0 and y = 2.0 - value
	always_comb begin
		qcx = (quox_q >= TEN_Q) ? TEN_Q[Q_W-1:0] : quox_q[Q_W-1:0];
		qcy = (quoy_q >= TEN_Q) ? TEN_Q[Q_W-1:0] : quoy_q[Q_W-1:0];
		dx  = $signed({1'b0, qcx}) - (Q_W+1)'(TWO_Q);
		dy  = (Q_W+1)'(TWO_Q) - $signed({1'b0, qcy});
		start.x = (dx > (Q_W+1)'(QMAX)) ? QMAX : dx[Q_W-1:0];
		start.y = dy[Q_W-1:0];
	end

	assign pix.ready = (state_q == F_IDLE);
	assign pt.valid  = (state_q == F_PUSH);
	assign pt.point  = start;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (pix.valid) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					state_q <= F_SUM;
				end
				F_SUM: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (pt.ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// scaling datapath
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && pix.valid) begin
			px_q <= pix.pixel_x;
			py_q <= pix.pixel_y;
		end else if (state_q == F_MUL) begin
			wholex_q <= NUM_W'(px_q) * WHOLE;
			wholey_q <= NUM_W'(py_q) * WHOLE;
			partx_q  <= PART_W'(px_q) * PART;
			party_q  <= PART_W'(py_q) * PART;
		end else if (state_q == F_SUM) begin
			quox_q <= wholex_q + NUM_W'(fracx[FPR_W-1:RCP_SH]);
			quoy_q <= wholey_q + NUM_W'(fracy[FPR_W-1:RCP_SH]);
		end
	end

endmodule
`default_nettype wire

// File: rtl/jet_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jet_queue
// Two-entry start point queue between the mapper and the iteration engine.
// ----------------------------------------------------------------------------
module jet_queue (
	input  logic     clk,
	input  logic     arst_n,
	jet_pt_if.sink   wr,
	jet_pt_if.source rd
);
	import jet_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	point_t            slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              push, pop;

	assign wr.ready = (fill_q != FILL_W'(DEPTH));
	assign rd.valid = (fill_q != '0);
	assign rd.point = slot_q[rd_ptr_q];
	assign push     = wr.valid & wr.ready;
	assign pop      = rd.valid & rd.ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr.point;
		end
	end

endmodule
`default_nettype wire

// File: rtl/jet_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jet_back
// Iterates z = z*z + c in three steps per iteration: multiply, round, add.
// ----------------------------------------------------------------------------
module jet_back (
	input  logic          clk,
	input  logic          arst_n,
	input  jet_pkg::cfg_t cfg,
	jet_pt_if.sink        pt,
	jet_res_if.source     res
);
	import jet_pkg::*;

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_MUL  = 5'b00010,
		B_RND  = 5'b00100,
		B_ADD  = 5'b01000,
		B_EMIT = 5'b10000
	} back_state_t;

	back_state_t state_q;
	q_t          x_q, y_q;
	cnt_t        cnt_q;
	prod_t       pxx_s1, pyy_s1, pxy_s1;
	logic        xy_neg_s1;
	q_t          sqx_s2, sqy_s2, xy_s2;
	logic        res_valid_q;
	cnt_t        res_cnt_q;
	logic        res_in_set_q;

	logic [Q_W-1:0] mx, my;
	logic [PROD_W:0] radius;
	logic            go;
	q_t              diff, dbl, nx, ny;
	logic            emit;

	assign mx = mag_q(x_q);
	assign my = mag_q(y_q);

	// escape test on full products, and the loop bound
	assign radius = {1'b0, pxx_s1} + {1'b0, pyy_s1};
	assign go     = (radius < RADIUS_SQ) && (cnt_q < cfg.iter_limit);

	// next z from rounded products
	always_comb begin
		diff = sat_q(qx_t'(sqx_s2) - qx_t'(sqy_s2));
		nx   = sat_q(qx_t'(diff) + qx_t'(cfg.c_real));
		dbl  = sat_q(qx_t'(xy_s2) + qx_t'(xy_s2));
		ny   = sat_q(qx_t'(dbl) + qx_t'(cfg.c_imag));
	end

	assign emit = (state_q == B_EMIT) && (!res_valid_q || res.ready);

	assign pt.ready            = (state_q == B_IDLE);
	assign res.valid           = res_valid_q;
	assign res.iteration_count = res_cnt_q;
	assign res.in_set          = res_in_set_q;

	// sequencer and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: if (pt.valid) state_q <= B_MUL;
				B_MUL:  state_q <= B_RND;
				B_RND:  state_q <= go ? B_ADD : B_EMIT;
				B_ADD:  state_q <= B_MUL;
				B_EMIT: if (emit) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// iteration datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				x_q   <= pt.point.x;
				y_q   <= pt.point.y;
				cnt_q <= '0;
			end
			B_MUL: begin
				pxx_s1    <= PROD_W'(mx) * PROD_W'(mx);
				pyy_s1    <= PROD_W'(my) * PROD_W'(my);
				pxy_s1    <= PROD_W'(mx) * PROD_W'(my);
				xy_neg_s1 <= x_q[Q_W-1] ^ y_q[Q_W-1];
			end
			B_RND: begin
				sqx_s2 <= prod_to_q(pxx_s1, 1'b0);
				sqy_s2 <= prod_to_q(pyy_s1, 1'b0);
				xy_s2  <= prod_to_q(pxy_s1, xy_neg_s1);
			end
			B_ADD: begin
				x_q   <= nx;
				y_q   <= ny;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
		if (emit) begin
			res_cnt_q    <= cnt_q;
			res_in_set_q <= (cnt_q == cfg.iter_limit);
		end
	end

endmodule
`default_nettype wire

// File: rtl/julia_escape_time_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// julia_escape_time_core
// Julia set escape-time engine, pixel in, iteration count and in-set flag out.
// ----------------------------------------------------------------------------
// Flow: the mapper takes one pixel at a time through its multiply and sum states,
//   the start point passes through a two-word queue, and the engine runs the
//   multiply, round and add steps of each iteration until escape or the limit.
// The engine works on one start point at a time; the mapping overlaps it via the queue.
// Reset: arst_n clears all control; c_real and c_imag reset to 0,
//   the iteration limit to 10000; a stalled result word holds the engine.
module julia_escape_time_core #(
	parameter int IMAGE_SIZE = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [jet_pkg::IDX_W-1:0] cfg_index,
	input  logic [jet_pkg::CFG_W-1:0] cfg_data,
	jet_pix_if.sink                   pix,
	jet_res_if.source                 res
);
	import jet_pkg::*;

	cfg_t cfg_q;

	jet_pt_if front_to_queue ();
	jet_pt_if queue_to_back ();

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_real     <= '0;
			cfg_q.c_imag     <= '0;
			cfg_q.iter_limit <= MAX_ITER_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_C_REAL:   cfg_q.c_real     <= q_t'(cfg_data);
				REG_C_IMAG:   cfg_q.c_imag     <= q_t'(cfg_data);
				REG_MAX_ITER: cfg_q.iter_limit <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// pixel to start point mapping
	jet_front #(
		.IMAGE_SIZE(IMAGE_SIZE)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.pix   (pix),
		.pt    (front_to_queue.source)
	);

	// decoupling queue
	jet_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (front_to_queue.sink),
		.rd    (queue_to_back.source)
	);

	// iteration engine
	jet_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.pt    (queue_to_back.sink),
		.res   (res)
	);

endmodule
`default_nettype wire

// File: tb/sv/tb_julia_escape_time_core.sv
// ----------------------------------------------------------------------------
// tb_julia_escape_time_core
// Self-checking bench for the Julia escape-time core. Pixels go in over the
// valid/ready channel with bursty timing, results drain through a receiver that
// stalls on its own pattern. Each accepted pixel is run through a local
// fixed-point escape-time model and the predicted count and in-set flag are
// compared in order against the words that come out.
// ----------------------------------------------------------------------------
module tb_julia_escape_time_core;
	import jet_pkg::*;

	localparam int     IMAGE_SIZE      = 4096;
	localparam int     CLK_PERIOD      = 4;
	localparam longint TIMEOUT_CYCLES  = 2_000_000;
	localparam int     SETTLE_CYCLES   = 64;
	localparam int     RANDOM_PHASES   = 5;
	localparam int     ITEMS_PER_PHASE = 16;
	localparam int     MAX_REPORTS     = 10;

	// index with no register behind it
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	// receiver stall pattern, one bit per cycle
	localparam logic [15:0] STALL_PATTERN = 16'b1011_0011_1000_1101;

	typedef struct packed {
		cnt_t iteration_count;
		logic in_set;
	} escape_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wen;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	jet_pix_if pix();
	jet_res_if res();

	julia_escape_time_core #(
		.IMAGE_SIZE(IMAGE_SIZE)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix      (pix),
		.res      (res)
	);

	// local copy of the registers
	logic signed [CFG_W-1:0] c_real_word = '0;
	logic signed [CFG_W-1:0] c_imag_word = '0;
	cnt_t                    limit_word  = MAX_ITER_RESET;

	escape_t     escape_queue[$];
	int          mismatch_count = 0;
	int          burst_left     = 0;
	logic [15:0] stall_tick     = '0;

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// watchdog
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("tb_julia_escape_time_core NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------------
	// escape-time model
	// ------------------------------------------------------------------------

	function automatic longint clamp_q(longint v);
		if (v > longint'(QMAX)) begin
			return longint'(QMAX);
		end else if (v < longint'(QMIN)) begin
			return longint'(QMIN);
		end
		return v;
	endfunction

	// 4*p/IMAGE_SIZE rounded down to the fraction grid, capped at 10
	function automatic longint start_term(logic [PIX_W-1:0] p);
		longint t;
		t = (longint'(p) << (FRAC_BITS + 2)) / IMAGE_SIZE;
		if (t > (longint'(10) << FRAC_BITS)) begin
			t = longint'(10) << FRAC_BITS;
		end
		return t;
	endfunction

	// product back to the fraction grid, floor, then saturate
	function automatic longint mul_fix(longint a, longint b);
		return clamp_q((a * b) >>> FRAC_BITS);
	endfunction

	// |z|^2 < 4 on the full products
	function automatic bit within_radius(longint x, longint y);
		logic [64:0] sum_sq;
		sum_sq = 65'(x * x) + 65'(y * y);
		return sum_sq < (65'(1) << (2 * FRAC_BITS + 2));
	endfunction

	function automatic escape_t predict_escape(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
		longint  x, y, cr, ci, xx, yy, xy, nx;
		int      count;
		escape_t r;
		x     = clamp_q(start_term(px) - (longint'(2) << FRAC_BITS));
		y     = clamp_q((longint'(2) << FRAC_BITS) - start_term(py));
		// registers are Q4.28, the same grid as the core
		cr    = longint'(c_real_word);
		ci    = longint'(c_imag_word);
		count = 0;
		while (count < int'(limit_word) && within_radius(x, y)) begin
			xx    = mul_fix(x, x);
			yy    = mul_fix(y, y);
			xy    = mul_fix(x, y);
			nx    = clamp_q(clamp_q(xx - yy) + cr);
			y     = clamp_q(clamp_q(xy + xy) + ci);
			x     = nx;
			count = count + 1;
		end
		r.iteration_count = cnt_t'(count);
		r.in_set          = (count == int'(limit_word));
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// one pixel word, bursts of random length with random gaps between them
	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap       = $urandom_range(1, 12);
			pix.valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
		end
		pix.valid   = 1'b1;
		pix.pixel_x = px;
		pix.pixel_y = py;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		escape_queue.push_back(predict_escape(px, py));
		burst_left = burst_left - 1;
	endtask

	// stop sending and wait for every predicted word to come back
	task automatic drain_results();
		@(negedge clk);
		pix.valid = 1'b0;
		while (escape_queue.size() != 0) @(negedge clk);
	endtask

	// register write, only called with the core idle
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		pix.valid = 1'b0;
		cfg_wen   = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_wen = 1'b0;
		case (idx)
			REG_C_REAL: begin
				c_real_word = data;
			end
			REG_C_IMAG: begin
				c_imag_word = data;
			end
			REG_MAX_ITER: begin
				limit_word = data[CNT_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	// receiver ready: always-on, fixed pattern, light and heavy random stalls
	always @(negedge clk) begin
		stall_tick <= stall_tick + 16'd1;
		case (stall_tick[10:9])
			2'd0: begin
				res.ready <= 1'b1;
			end
			2'd1: begin
				res.ready <= STALL_PATTERN[stall_tick[3:0]];
			end
			2'd2: begin
				res.ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				res.ready <= ($urandom_range(0, 1) != 0);
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// result check
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		escape_t want;
		if (arst_n && res.valid && res.ready) begin
			if (escape_queue.size() == 0) begin
				mismatch_count = mismatch_count + 1;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("unexpected result word: count %0d in_set %0b",
						res.iteration_count, res.in_set);
				end
			end else begin
				want = escape_queue.pop_front();
				if (res.iteration_count !== want.iteration_count
						|| res.in_set !== want.in_set) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("result mismatch: expected count %0d in_set %0b, got count %0d in_set %0b",
							want.iteration_count, want.in_set,
							res.iteration_count, res.in_set);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset values: c = 0, limit 10000
	task automatic test_reset_state();
		send_pixel(12'd2048, 12'd2048);	// z = 0 never leaves, full limit
		send_pixel(12'd0, 12'd0);	// corner, outside at once
		send_pixel(12'd4095, 12'd4095);	// opposite corner
		send_pixel(12'd2048, 12'd0);	// exactly on the radius
		send_pixel(12'd1024, 12'd3072);	// -1-1i, escapes after one step
	endtask

	// limit of one, zero, with junk in the upper bits, and the largest
	task automatic test_iteration_limits();
		drain_results();
		write_reg(REG_MAX_ITER, 32'd1);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd1024, 12'd3072);	// escapes on the step that hits the limit
		drain_results();
		write_reg(REG_MAX_ITER, 32'd0);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd0, 12'd0);
		drain_results();
		write_reg(REG_MAX_ITER, 32'hABCD_0005);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd1024, 12'd3072);
		drain_results();
		write_reg(REG_MAX_ITER, 32'h0000_FFFF);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd2048, 12'd2048);
	endtask

	// constants at the ends of the range drive the sums into saturation
	task automatic test_constant_extremes();
		drain_results();
		write_reg(REG_MAX_ITER, 32'd16);
		write_reg(REG_C_REAL, 32'h7FFF_FFFF);
		write_reg(REG_C_IMAG, 32'h8000_0000);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd3500, 12'd2048);
		drain_results();
		write_reg(REG_C_REAL, 32'h8000_0000);
		write_reg(REG_C_IMAG, 32'h7FFF_FFFF);
		send_pixel(12'd1024, 12'd3072);
		send_pixel(12'd2048, 12'd1000);
		// a classic connected constant, about -0.8 + 0.156i
		drain_results();
		write_reg(REG_MAX_ITER, 32'd255);
		write_reg(REG_C_REAL, -32'sd214748365);
		write_reg(REG_C_IMAG, 32'sd41875931);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd1500, 12'd2500);
	endtask

	// a write to the unused index leaves every register alone
	task automatic test_unknown_index();
		drain_results();
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd1700, 12'd2300);
	endtask

	// random constants and limits, random pixels biased toward the middle
	task automatic test_random_pixels();
		logic [CFG_W-1:0] cr, ci, lim;
		logic [PIX_W-1:0] px, py;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_results();
			if (phase == RANDOM_PHASES - 1 || $urandom_range(0, 4) == 0) begin
				cr = $urandom();
				ci = $urandom();
			end else begin
				// real and imaginary parts of c within one keep many points iterating
				cr = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
				ci = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
			end
			lim = ($urandom() & 32'hFFFF_0000) | $urandom_range(1, 300);
			write_reg(REG_C_REAL, cr);
			write_reg(REG_C_IMAG, ci);
			write_reg(REG_MAX_ITER, lim);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(0, 15) == 0) begin
					drain_results();
				end
				if ($urandom_range(0, 3) == 0) begin
					px = PIX_W'($urandom_range(1024, 3071));
					py = PIX_W'($urandom_range(1024, 3071));
				end else begin
					px = PIX_W'($urandom());
					py = PIX_W'($urandom());
				end
				send_pixel(px, py);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n      = 1'b0;
		cfg_wen     = 1'b0;
		cfg_index   = REG_C_REAL;
		cfg_data    = '0;
		pix.valid   = 1'b0;
		pix.pixel_x = '0;
		pix.pixel_y = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_iteration_limits();
		test_constant_extremes();
		test_unknown_index();
		test_random_pixels();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && escape_queue.size() == 0) begin
			$display("tb_julia_escape_time_core OK");
		end else begin
			$display("tb_julia_escape_time_core NOT OK");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/jet_pkg.sv
rtl/jet_if.sv
rtl/jet_front.sv
rtl/jet_queue.sv
rtl/jet_back.sv
rtl/julia_escape_time_core.sv
tb/sv/tb_julia_escape_time_core.sv
